### rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

	// register indexes on the configuration port (byte address = 8 * index)
	typedef enum logic [1:0] {
		REG_TARGET      = 2'd0,
		REG_REPLACEMENT = 2'd1,
		REG_LENGTH      = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	localparam int unsigned WIN_CAP   = 8;
	localparam int unsigned CNT_W     = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic [CNT_W-1:0] count;
	} out_entry_t;

endpackage

`default_nettype wire

### rtl/stream_find_replace_equal_length_top.sv
// Equal-length find and replace on a byte stream. The block accepts one byte per cycle while
// its input stage is not held, and writes each byte's results (0 to W bytes, W = min(MAX_LEN,
// 8)) into a 2*W entry result queue as the byte leaves the input stage register; the queue
// drains one result per cycle while out_ready is high. A byte waits in the input stage while
// the queue holds more than W results, so sustained throughput is one byte per cycle whenever
// the output side takes one byte per cycle. Registers (64-bit APB, byte address 8*i): target
// string, replacement string, string length (0 acts as 1, values above W act as W).
// Write configuration only with the queue empty and the input stage idle.
`default_nettype none

module stream_find_replace_equal_length_top #(
	parameter int MAX_LEN = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [31:0]      match_count,
	output logic             out_valid,
	input  wire logic        out_ready
);
	import sfr_pkg::*;

	localparam int WD = (MAX_LEN < WIN_CAP) ? MAX_LEN : WIN_CAP;
	localparam int QD = 2 * WD;
	localparam int FW = $clog2(WD + 1);
	localparam int CW = $clog2(QD + 1);

	// configuration
	logic [63:0] target_q;
	logic [63:0] repl_q;
	logic [3:0]  length_q;
	reg_idx_t    widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			repl_q   <= '0;
			length_q <= 4'd1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_TARGET:      target_q <= pwdata;
				REG_REPLACEMENT: repl_q   <= pwdata;
				REG_LENGTH:      length_q <= pwdata[3:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_TARGET:      prdata = target_q;
			REG_REPLACEMENT: prdata = repl_q;
			REG_LENGTH:      prdata = {60'd0, length_q};
			default:         prdata = '0;
		endcase
	end

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire;

	logic [CW-1:0] cnt_q;

	assign fire     = vld_s1 && (cnt_q <= CW'(QD - WD));
	assign in_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// pending window and tally
	logic [7:0]       win_q [WD];
	logic [FW-1:0]    fill_q;
	logic [CNT_W-1:0] tally_q;

	logic [3:0]       len4;
	logic [FW-1:0]    len;
	logic [7:0]       seq [WD];
	logic [FW-1:0]    num;
	logic [FW-1:0]    drain;
	logic             full;
	logic             hit;
	logic [FW-1:0]    emit_n;
	logic [FW-1:0]    res_n;
	logic [CNT_W-1:0] tally_inc;
	out_entry_t       res [WD];
	logic [7:0]       win_d [WD];
	logic [FW-1:0]    fill_d;

	always_comb begin
		if (length_q == 4'd0)
			len4 = 4'd1;
		else if (length_q > 4'(WD))
			len4 = 4'(WD);
		else
			len4 = length_q;
		len = FW'(len4);
	end

	// pending bytes followed by the new byte
	always_comb begin
		for (int i = 0; i < WD; i++) begin
			if (i < fill_q)
				seq[i] = win_q[i];
			else if (i == fill_q)
				seq[i] = byte_s1;
			else
				seq[i] = 8'h00;
		end
	end

	assign num   = fill_q + 1'b1;
	assign full  = (num >= len);
	// oldest bytes passed through before the compare when the length was lowered
	assign drain = (fill_q >= len) ? (fill_q - len + 1'b1) : '0;

	always_comb begin
		logic [7:0] cand;
		hit = full;
		for (int i = 0; i < WD; i++) begin
			cand = 8'h00;
			for (int j = 0; j < WD; j++) begin
				if (j == drain + i)
					cand = seq[j];
			end
			if (i < len && cand != target_q[8*i +: 8])
				hit = 1'b0;
		end
	end

	always_comb begin
		if (last_s1)
			emit_n = num;
		else if (full)
			emit_n = drain + 1'b1;
		else
			emit_n = '0;
		res_n = hit ? num : emit_n;
	end

	assign tally_inc = (tally_q == CNT_MAX) ? tally_q : tally_q + 1'b1;

	always_comb begin
		logic [7:0] rb;
		for (int j = 0; j < WD; j++) begin
			rb = 8'h00;
			for (int i = 0; i < WD; i++) begin
				if (i + drain == j)
					rb = repl_q[8*i +: 8];
			end
			if (hit && j >= drain) begin
				res[j].data  = rb;
				res[j].count = tally_inc;
			end else begin
				res[j].data  = seq[j];
				res[j].count = tally_q;
			end
			res[j].last = last_s1 && (j + 1 == res_n);
		end
	end

	always_comb begin
		for (int i = 0; i < WD; i++) begin
			win_d[i] = win_q[i];
			if (!hit) begin
				for (int j = 0; j < WD; j++) begin
					if (j == emit_n + i)
						win_d[i] = seq[j];
				end
			end
		end
		fill_d = hit ? '0 : (num - emit_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			tally_q <= '0;
		end else if (fire) begin
			fill_q <= fill_d;
			if (last_s1)
				tally_q <= '0;
			else if (hit)
				tally_q <= tally_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < WD; i++)
				win_q[i] <= win_d[i];
		end
	end

	// result queue, head at entry 0
	out_entry_t    q [QD];
	out_entry_t    q_d [QD];
	logic          pop;
	logic [CW-1:0] base;

	assign out_valid   = (cnt_q != '0);
	assign out_byte    = q[0].data;
	assign out_last    = q[0].last;
	assign match_count = q[0].count;
	assign pop         = out_valid && out_ready;
	assign base        = cnt_q - CW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + (fire ? CW'(res_n) : '0);
		end
	end

	// shift on a pop, then new results land behind the surviving entries
	always_comb begin
		for (int s = 0; s < QD; s++) begin
			if (pop && s + 1 < QD)
				q_d[s] = q[s + 1];
			else
				q_d[s] = q[s];
			if (fire) begin
				for (int j = 0; j < WD; j++) begin
					if (j < res_n && s == base + j)
						q_d[s] = res[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < QD; s++)
			q[s] <= q_d[s];
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(QD))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n) fill_q < FW'(WD))
		else $error("pending window overfilled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (fill_q == '0 && tally_q == '0))
		else $error("stream end did not flush window and clear tally");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !last_s1 && !hit) |=> (tally_q == $past(tally_q)))
		else $error("tally changed without a replacement");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sfr_pkg::*;

	localparam int     MAX_LEN        = 8;
	localparam real    CLK_PERIOD     = 20.0;
	localparam int     RESET_CYCLES   = 7;
	localparam int     SETTLE_CYCLES  = 6;
	localparam int     LONG_STALL     = 80;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     PHASES         = 3;
	localparam int     CONFIGS        = 4;
	localparam int     BYTES_PER_CFG  = 21;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [63:0] val;
		logic [7:0]  data;
		logic        last;
		logic        typed;
		out_entry_t  want;
	} script_row_t;

	localparam out_entry_t NO_WANT = '0;

	// Opens at reset state (target 0, replacement 0, length 1), then length 0 acting as 1,
	// length 15 clamped to 8 with a full-window miss followed by a hit, and length lowered
	// from 8 to 2 with five bytes pending.
	localparam script_row_t SCRIPT [0:28] = '{
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b1,
			'{8'h00, 1'b0, 32'd1}},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'hFF, 1'b1, 1'b1,
			'{8'hFF, 1'b1, 32'd1}},
		'{ROW_CFG,  REG_LENGTH,      64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_TARGET,      64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_REPLACEMENT, 64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b1,
			'{8'h00, 1'b0, 32'd0}},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'hFF, 1'b1, 1'b1,
			'{8'h00, 1'b1, 32'd1}},
		'{ROW_CFG,  REG_LENGTH,      64'd15,                 8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_TARGET,      64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_REPLACEMENT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h01, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h00, 1'b1, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_LENGTH,      64'd8,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_TARGET,      64'hDEAD_BEEF_0000_4645, 8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_REPLACEMENT, 64'h8877_6655_4433_2211, 8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h41, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h42, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h43, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h44, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h45, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_LENGTH,      64'd2,                  8'h00, 1'b0, 1'b0, NO_WANT},
		'{ROW_BYTE, REG_NONE,        64'd0,                  8'h46, 1'b1, 1'b0, NO_WANT}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [31:0] match_count;
	logic        out_valid;
	logic        out_ready;

	// predictor state and its copy of the registers
	logic [63:0]  cfg_target;
	logic [63:0]  cfg_repl;
	logic [3:0]   cfg_len;
	logic [7:0]   win [WIN_CAP];
	int unsigned  fill;
	logic [31:0]  tally;

	out_entry_t   burst_q [$];
	out_entry_t   rewritten_q [$];

	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	bit           stall_req;
	int unsigned  idle_cycles;
	int unsigned  mismatch_cnt;
	int unsigned  bytes_in;
	int unsigned  bytes_out;
	int unsigned  cfg_writes;

	stream_find_replace_equal_length_top #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.match_count(match_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2.0) clk = ~clk;

	function automatic int unsigned active_len();
		int unsigned cap;
		int unsigned l;
		cap = (MAX_LEN < WIN_CAP) ? MAX_LEN : WIN_CAP;
		if (cap < 1) cap = 1;
		l = cfg_len;
		if (l < 1) l = 1;
		if (l > cap) l = cap;
		return l;
	endfunction

	function automatic logic [7:0] shift_out();
		logic [7:0] b;
		b = win[0];
		for (int i = 1; i < WIN_CAP; i++) win[i-1] = win[i];
		win[WIN_CAP-1] = 8'h00;
		if (fill > 0) fill--;
		return b;
	endfunction

	function automatic void push_burst(input logic [7:0] b);
		burst_q.push_back('{data: b, last: 1'b0, count: tally});
	endfunction

	// fills burst_q with the bytes one input byte releases
	function automatic void rewrite_step(input logic [7:0] b, input logic last);
		int unsigned len;
		logic        hit;
		len = active_len();
		burst_q.delete();
		// a lowered length drains the oldest bytes first
		while (fill >= len && fill > 0) push_burst(shift_out());
		win[fill] = b;
		fill++;
		if (fill == len) begin
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (win[i] != cfg_target[8*i +: 8]) hit = 1'b0;
			if (hit) begin
				if (tally != CNT_MAX) tally++;
				for (int i = 0; i < len; i++) push_burst(cfg_repl[8*i +: 8]);
				for (int i = 0; i < WIN_CAP; i++) win[i] = 8'h00;
				fill = 0;
			end else begin
				push_burst(shift_out());
			end
		end
		if (last) begin
			while (fill > 0) push_burst(shift_out());
			if (burst_q.size() > 0) burst_q[burst_q.size()-1].last = 1'b1;
			tally = '0;
		end
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_TARGET:      cfg_target = val;
			REG_REPLACEMENT: cfg_repl   = val;
			REG_LENGTH:      cfg_len    = val[3:0];
			default: ;
		endcase
	endtask

	// drop valid, let every predicted byte come out, then give the pipe time to go idle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (rewritten_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic sender_idle();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
			input out_entry_t want);
		sender_idle();
		in_byte  <= data;
		in_last  <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		bytes_in++;
		rewrite_step(data, last);
		if (typed) rewritten_q.push_back(want);
		else foreach (burst_q[i]) rewritten_q.push_back(burst_q[i]);
	endtask

	// mostly copies of the target, some with one byte spoiled, plus noise
	task automatic send_stream(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		int unsigned spoil;
		logic [7:0]  b;
		sent = 0;
		len  = active_len();
		while (sent < count) begin
			if ($urandom_range(99) < 65) begin
				spoil = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : len;
				for (int k = 0; k < len && sent < count; k++) begin
					b = cfg_target[8*k +: 8];
					if (k == spoil) b = b ^ 8'($urandom_range(1, 255));
					send_byte(b, $urandom_range(15) == 0, 1'b0, NO_WANT);
					sent++;
				end
			end else begin
				if ($urandom_range(1) == 0) b = 8'($urandom_range(255));
				else b = cfg_target[8*$urandom_range(len - 1) +: 8];
				send_byte(b, $urandom_range(7) == 0, 1'b0, NO_WANT);
				sent++;
			end
		end
	endtask

	initial begin
		logic [63:0] tgt;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_byte       = '0;
		in_last       = 1'b0;
		in_valid      = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req     = 1'b0;
		mismatch_cnt  = 0;
		bytes_in      = 0;
		bytes_out     = 0;
		cfg_writes    = 0;
		cfg_target    = '0;
		cfg_repl      = '0;
		cfg_len       = 4'd1;
		fill          = 0;
		tally         = '0;
		for (int i = 0; i < WIN_CAP; i++) win[i] = 8'h00;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[r]) begin
			if (SCRIPT[r].kind == ROW_CFG) begin
				wait_quiet();
				reg_write(SCRIPT[r].idx, SCRIPT[r].val);
			end else begin
				send_byte(SCRIPT[r].data, SCRIPT[r].last, SCRIPT[r].typed, SCRIPT[r].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 45 : 0;
			recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 28 : 0;
			for (int c = 0; c < CONFIGS; c++) begin
				// config lands between streams or mid-stream; pipe drained either way
				wait_quiet();
				tgt = {$urandom, $urandom};
				// two-letter alphabet gives partial and self-overlapping targets
				if ($urandom_range(1) == 0) tgt = (tgt & 64'h0101_0101_0101_0101) |
					64'h6060_6060_6060_6060;
				reg_write(REG_TARGET, tgt);
				reg_write(REG_REPLACEMENT, {$urandom, $urandom});
				reg_write(REG_LENGTH, (c == 0) ? 64'd1 : (c == 1) ? 64'd8 :
					64'($urandom_range(15)));
				if (ph == 0 && c == 1) stall_req = 1'b1;
				send_stream(BYTES_PER_CFG);
			end
		end

		wait_quiet();
		$display("tb_top: %0d bytes in, %0d bytes out, %0d register writes, %0d mismatches",
			bytes_in, bytes_out, cfg_writes, mismatch_cnt);
		$display("tb_top: lengths 0..15, mid-stream length changes, long output stall covered");
		if (mismatch_cnt == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stall_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		out_entry_t want;
		if (arst_n && out_valid && out_ready) begin
			bytes_out++;
			if (rewritten_q.size() == 0) begin
				$error("unexpected output transfer: out_byte %02h out_last %0b match_count %0d",
					out_byte, out_last, match_count);
				mismatch_cnt++;
			end else begin
				want = rewritten_q.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, out_byte);
					mismatch_cnt++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %0b, got %0b", want.last, out_last);
					mismatch_cnt++;
				end
				if (match_count !== want.count) begin
					$error("match_count: expected %0d, got %0d", want.count, match_count);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb_top: watchdog expired, %0d bytes still outstanding", rewritten_q.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

endmodule
